### sv/polyev_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyev_pkg
// Shared types, codes and the microcode program of the polynomial evaluator.
// ----------------------------------------------------------------------------
package polyev_pkg;

  // Command codes carried on the input tuser bit
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef logic [2:0] step_t;

  // Program step addresses
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_FETCH = 3'd1;
  localparam step_t STEP_LOAD  = 3'd2;
  localparam step_t STEP_MUL   = 3'd3;
  localparam step_t STEP_ADD   = 3'd4;
  localparam step_t STEP_DONE  = 3'd5;

  // Jump conditions
  typedef enum logic [2:0] {
    JC_NEXT,      // fall through
    JC_START,     // jump on evaluate request, else hold
    JC_PTR_ZERO,  // jump if pointer is zero, else fall through
    JC_PTR_NZ,    // jump if pointer is nonzero, else fall through
    JC_OUT_FREE   // jump once the result slot is free, else hold
  } jc_t;

  typedef struct packed {
    logic  rd_en;   // read coefficient table
    logic  rd_dec;  // read at pointer - 1 and step the pointer down
    logic  ld_acc;  // acc <= coefficient, clear overflow
    logic  mul;     // product <= acc * x
    logic  add;     // acc <= sat(round(product) + coefficient)
    logic  out_ld;  // load result register
    jc_t   jc;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic ptr_zero;
    logic out_busy;
  } stat_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{rd_en: 1'b0, rd_dec: 1'b0, ld_acc: 1'b0, mul: 1'b0, add: 1'b0,
          out_ld: 1'b0, jc: JC_NEXT, target: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        w.jc     = JC_START;
        w.target = STEP_FETCH;
      end
      STEP_FETCH: begin
        w.rd_en = 1'b1;
      end
      STEP_LOAD: begin
        w.ld_acc = 1'b1;
        w.jc     = JC_PTR_ZERO;
        w.target = STEP_DONE;
      end
      STEP_MUL: begin
        w.mul    = 1'b1;
        w.rd_en  = 1'b1;
        w.rd_dec = 1'b1;
      end
      STEP_ADD: begin
        w.add    = 1'b1;
        w.jc     = JC_PTR_NZ;
        w.target = STEP_MUL;
      end
      STEP_DONE: begin
        w.out_ld = 1'b1;
        w.jc     = JC_OUT_FREE;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jc     = JC_OUT_FREE;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### sv/polynomial_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_evaluator_unit
// Horner evaluation of a signed Q16.16 polynomial, microcoded control.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake            | Payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: command; tdata: index, coeff, x
//  out_    | out | out_tvalid/out_tready| tdata: result_value, overflow
//  cfg_    | in  | cfg_wr_en            | cfg_wr_data: degree
//
//  A write request leaves the sequencer in its idle step. An evaluate request
//  occupies it from acceptance until the next request can be accepted (the
//  degree clamped): one multiply step and one round/add/saturate step per
//  coefficient below the top one through the single shared multiplier, plus
//  fetch, load and result steps. Reset is synchronous; the table reads zero
//  and degree is 0. A result waiting on out_tready holds the sequencer in its
//  result step only if a second result is ready to replace it.
// ----------------------------------------------------------------------------
module polynomial_evaluator_unit #(
  parameter int MAX_POLY_DEGREE = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,   // degree
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,      // [0] command
  input  logic [71:0] in_tdata,      // [3:0] coeff_index, [35:4] coeff_value,
                                     // [67:36] x_value, [71:68] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata      // [31:0] result_value, [32] overflow,
                                     // [39:33] zero
);
  import polyev_pkg::*;

  logic   in_acc;
  logic   wr_req;
  logic   start;
  uword_t cw;
  stat_t  st;
  logic signed [31:0] result_value;
  logic   overflow;

  // Decode the accepted request into a table write or an evaluation start
  assign in_acc = in_tvalid && in_tready;
  assign wr_req = in_acc && (in_tuser == CMD_WRITE);
  assign start  = in_acc && (in_tuser == CMD_EVAL);

  polyev_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .st       (st),
    .cw       (cw),
    .in_ready (in_tready)
  );

  polyev_datapath #(
    .MAX_POLY_DEGREE (MAX_POLY_DEGREE)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .wr_req       (wr_req),
    .start        (start),
    .coeff_index  (in_tdata[3:0]),
    .coeff_value  (in_tdata[35:4]),
    .x_value      (in_tdata[67:36]),
    .cw           (cw),
    .st           (st),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .result_value (result_value),
    .overflow     (overflow)
  );

  // Pack the result; pad to whole bytes
  assign out_tdata = {7'd0, overflow, result_value};

endmodule

### sv/polyev_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyev_sequencer
// Step counter and jump logic over the microcode program.
// ----------------------------------------------------------------------------
module polyev_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  polyev_pkg::stat_t  st,
  output polyev_pkg::uword_t cw,
  output logic               in_ready
);
  import polyev_pkg::*;

  step_t  pc_r, pc_nxt;
  uword_t rom_w;

  assign rom_w = ucode(pc_r);

  always_comb begin
    cw        = rom_w;
    cw.out_ld = rom_w.out_ld & ~st.out_busy;
  end

  assign in_ready = (pc_r == STEP_IDLE);

  always_comb begin
    case (rom_w.jc)
      JC_NEXT:     pc_nxt = pc_r + 3'd1;
      JC_START:    pc_nxt = start ? rom_w.target : pc_r;
      JC_PTR_ZERO: pc_nxt = st.ptr_zero ? rom_w.target : pc_r + 3'd1;
      JC_PTR_NZ:   pc_nxt = st.ptr_zero ? pc_r + 3'd1 : rom_w.target;
      JC_OUT_FREE: pc_nxt = st.out_busy ? pc_r : rom_w.target;
      default:     pc_nxt = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### sv/polyev_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyev_datapath
// Coefficient memory, multiplier, round/add/saturate and result register.
// ----------------------------------------------------------------------------
module polyev_datapath #(
  parameter int MAX_POLY_DEGREE = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,
  input  logic               wr_req,
  input  logic               start,
  input  logic [3:0]         coeff_index,
  input  logic signed [31:0] coeff_value,
  input  logic signed [31:0] x_value,
  input  polyev_pkg::uword_t cw,
  output polyev_pkg::stat_t  st,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] result_value,
  output logic               overflow
);
  import polyev_pkg::*;

  localparam int DEPTH = MAX_POLY_DEGREE + 1;
  localparam int PW    = $clog2(DEPTH);

  logic [31:0]       mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [31:0]       rdata_r;
  logic              rvld_r;
  logic [3:0]        degree_r;
  logic [PW-1:0]     ptr_r;
  logic [PW-1:0]     raddr;
  logic signed [31:0] x_r, acc_r;
  logic signed [63:0] prod_r;
  logic              ovf_r;
  logic              out_valid_r;
  logic [31:0]       res_r;
  logic              res_ovf_r;
  logic [31:0]       coef;
  logic [48:0]       sum;
  logic              sat_hi, sat_lo;
  logic [31:0]       acc_nxt;
  logic              idx_ok;

  assign idx_ok = (32'(coeff_index) <= 32'(MAX_POLY_DEGREE));
  assign raddr  = cw.rd_dec ? ptr_r - 1'b1 : ptr_r;
  assign coef   = rvld_r ? rdata_r : 32'd0;

  // Round to nearest: floor((p + 2^15) / 2^16) = p[63:16] + p[15]
  assign sum = {prod_r[63], prod_r[63:16]} + {{17{coef[31]}}, coef}
             + {48'd0, prod_r[15]};
  assign sat_hi = !sum[48] && (sum[47:31] != 17'd0);
  assign sat_lo =  sum[48] && (sum[47:31] != {17{1'b1}});
  assign acc_nxt = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : sum[31:0]);

  always_ff @(posedge clk) begin
    if (wr_req && idx_ok) begin
      mem[PW'(coeff_index)] <= coeff_value;
    end
    if (cw.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      rvld_r      <= 1'b0;
      degree_r    <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_req && idx_ok) begin
        vld_r[PW'(coeff_index)] <= 1'b1;
      end
      if (cw.rd_en) begin
        rvld_r <= vld_r[raddr];
      end
      if (cfg_wr_en) begin
        degree_r <= cfg_wr_data;
      end
      if (cw.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_value;
      if (32'(degree_r) > 32'(MAX_POLY_DEGREE)) begin
        ptr_r <= PW'(MAX_POLY_DEGREE);
      end else begin
        ptr_r <= PW'(degree_r);
      end
    end else if (cw.rd_dec) begin
      ptr_r <= ptr_r - 1'b1;
    end
    if (cw.ld_acc) begin
      acc_r <= coef;
      ovf_r <= 1'b0;
    end else if (cw.add) begin
      acc_r <= acc_nxt;
      ovf_r <= ovf_r | sat_hi | sat_lo;
    end
    if (cw.mul) begin
      prod_r <= acc_r * x_r;
    end
    if (cw.out_ld) begin
      res_r     <= acc_r;
      res_ovf_r <= ovf_r;
    end
  end

  assign st.ptr_zero  = (ptr_r == '0);
  assign st.out_busy  = out_valid_r & ~out_ready;
  assign out_valid    = out_valid_r;
  assign result_value = res_r;
  assign overflow     = res_ovf_r;

`ifndef SYNTH
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cw.rd_dec |-> !st.ptr_zero)
    else $error("pointer stepped below zero");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_req && cw.rd_en))
    else $error("table write during evaluation");
  a_ovf_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cw.ld_acc |=> !ovf_r)
    else $error("overflow not cleared at load");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cw.out_ld |-> !(out_valid_r && !out_ready))
    else $error("result overwritten before taken");
`endif

endmodule

### bench/polynomial_evaluator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_evaluator_unit_test
// Self-checking bench for the Horner polynomial evaluator. A short table of
// directed requests covers reset contents, field extremes, rounding ties,
// saturation in both directions and ignored high coefficients. Random
// requests follow, in phases at different degrees and with different
// amounts of idling on both streams. A shadow table and a Horner predictor
// supply value and overflow flag for evaluate requests with no typed result.
// ----------------------------------------------------------------------------
module polynomial_evaluator_unit_test;
  import polyev_pkg::*;

  localparam int  DEPTH        = 16;
  localparam int  DRAIN_PAUSE  = 40;    // longer than a full evaluation at degree 15
  localparam int  IDLE_LIMIT   = 2000;  // cycles with no transfer before giving up
  localparam int  PHASES       = 10;
  localparam int  PHASE_ITEMS  = 75;
  localparam longint Q_MAX     = 64'sd2147483647;
  localparam longint Q_MIN     = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
  } poly_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_EVAL, ROW_DEGREE} row_kind_t;

  // One directed row. For ROW_EVAL, value is x; for ROW_DEGREE, value[3:0]
  // is the degree. Rows with fixed set carry their result typed in.
  typedef struct packed {
    row_kind_t    kind;
    logic [3:0]   idx;
    logic [31:0]  value;
    logic         fixed;
    poly_result_t res;
  } stim_row_t;

  localparam int N_ROWS = 23;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // Table is all zero after reset, degree 0
    '{ROW_EVAL,   4'd0,  32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0}},
    // Degree zero returns c[0] untouched
    '{ROW_WRITE,  4'd0,  32'h8000_0000, 1'b0, '0},
    '{ROW_EVAL,   4'd0,  32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b0}},
    // Full degree, largest top coefficient: positive saturation
    '{ROW_WRITE,  4'd15, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_DEGREE, 4'd0,  32'd15,        1'b0, '0},
    '{ROW_EVAL,   4'd0,  32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 1'b1}},
    '{ROW_EVAL,   4'd0,  32'h8000_0000, 1'b0, '0},
    '{ROW_EVAL,   4'd0,  32'h0000_0000, 1'b1, '{32'h8000_0000, 1'b0}},
    // 1 + x at degree 1; c[2] lies above the degree and must be ignored
    '{ROW_WRITE,  4'd15, 32'h0000_0000, 1'b0, '0},
    '{ROW_WRITE,  4'd0,  32'h0001_0000, 1'b0, '0},
    '{ROW_WRITE,  4'd1,  32'h0001_0000, 1'b0, '0},
    '{ROW_WRITE,  4'd2,  32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_DEGREE, 4'd0,  32'd1,         1'b0, '0},
    '{ROW_EVAL,   4'd0,  32'h0001_0000, 1'b1, '{32'h0002_0000, 1'b0}},
    // Rounding ties: +half rounds up, -half rounds up to zero
    '{ROW_WRITE,  4'd1,  32'h0000_0001, 1'b0, '0},
    '{ROW_EVAL,   4'd0,  32'h0000_8000, 1'b0, '0},
    '{ROW_WRITE,  4'd1,  32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_EVAL,   4'd0,  32'h0000_8000, 1'b0, '0},
    // Negative and positive saturation at degree 1
    '{ROW_WRITE,  4'd1,  32'h8000_0000, 1'b0, '0},
    '{ROW_WRITE,  4'd0,  32'h8000_0000, 1'b0, '0},
    '{ROW_EVAL,   4'd0,  32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, 1'b1}},
    '{ROW_EVAL,   4'd0,  32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, 1'b1}},
    '{ROW_EVAL,   4'd0,  32'hFFFF_FFFF, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  // Shadow of the block's state, updated as requests are accepted
  logic signed [31:0] coef_shadow [DEPTH];
  logic [3:0]         degree_shadow;

  poly_result_t pending_evals [$];

  int fail_count;
  int send_gap_max;
  int stall_max;
  int stall_left;
  int idle_cycles;

  polynomial_evaluator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Horner's rule on the shadow table: exact 64-bit product, round half up,
  // saturate each step to 32 bits and remember whether any step clipped.
  function automatic poly_result_t horner_eval(logic signed [31:0] x);
    poly_result_t r;
    longint       acc;
    int           k;
    r.ovf = 1'b0;
    acc   = longint'(coef_shadow[degree_shadow]);
    for (k = int'(degree_shadow); k > 0; k--) begin
      acc = ((acc * longint'(x) + 64'sd32768) >>> 16) + longint'(coef_shadow[k - 1]);
      if (acc > Q_MAX) begin
        acc   = Q_MAX;
        r.ovf = 1'b1;
      end else if (acc < Q_MIN) begin
        acc   = Q_MIN;
        r.ovf = 1'b1;
      end
    end
    r.value = acc[31:0];
    return r;
  endfunction

  // Mostly moderate Q16.16 values, with full-range words and extremes mixed in.
  function automatic logic [31:0] draw_q(int span);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return $urandom;
    if (pick == 2) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Present one request after a random gap and hold it until accepted.
  // tvalid stays high afterwards so back-to-back requests need no bubble.
  task automatic send_request(logic cmd, logic [3:0] idx, logic [31:0] coeff,
                              logic [31:0] x, logic fixed, poly_result_t fixed_res);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, x, coeff, idx};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_WRITE) begin
      coef_shadow[idx] = coeff;
    end else begin
      pending_evals.push_back(fixed ? fixed_res : horner_eval(x));
    end
  endtask

  // Drop tvalid, wait for every result, then give a trailing write time to land.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_evals.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic set_degree(logic [3:0] d);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    degree_shadow  = d;
  endtask

  // Result side: after each accepted result, stall a random number of cycles.
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tready && out_tvalid) begin
      stall = $urandom_range(0, stall_max);
      if (stall != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall - 1;
      end
    end else if (!out_tready) begin
      if (stall_left == 0) out_tready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    poly_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_evals.size() == 0) begin
        $error("result_value %h arrived with nothing expected", out_tdata[31:0]);
        fail_count++;
      end else begin
        want = pending_evals.pop_front();
        if (out_tdata[31:0] !== want.value) begin
          $error("result_value: expected %h, actual %h", want.value, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[32] !== want.ovf) begin
          $error("overflow: expected %b, actual %b", want.ovf, out_tdata[32]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph;
    int n;
    int mode;
    logic cmd;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 4'd0;
    in_tvalid     <= 1'b0;
    in_tuser      <= CMD_WRITE;
    in_tdata      <= '0;
    idle_cycles   <= 0;
    fail_count     = 0;
    send_gap_max   = 11;
    stall_max      = 11;
    degree_shadow  = 4'd0;
    for (n = 0; n < DEPTH; n++) coef_shadow[n] = 32'sd0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (n = 0; n < N_ROWS; n++) begin
      case (DIRECTED[n].kind)
        ROW_DEGREE: set_degree(DIRECTED[n].value[3:0]);
        ROW_WRITE:  send_request(CMD_WRITE, DIRECTED[n].idx, DIRECTED[n].value,
                                 32'h0, 1'b0, '0);
        default:    send_request(CMD_EVAL, DIRECTED[n].idx, 32'h0,
                                 DIRECTED[n].value, DIRECTED[n].fixed, DIRECTED[n].res);
      endcase
    end

    // Random phases: each sets a degree while idle (the sender holds off
    // until all results are back) and picks how much both sides idle.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_degree(4'd15);
        1:       set_degree(4'd0);
        2:       set_degree(4'd1);
        default: set_degree(4'($urandom_range(0, 15)));
      endcase
      mode         = ph % 4;
      send_gap_max = (mode == 1 || mode == 2) ? 0 : 11;
      stall_max    = (mode == 1 || mode == 3) ? 0 : 11;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        cmd = $urandom_range(0, 1) ? CMD_EVAL : CMD_WRITE;
        send_request(cmd, 4'($urandom_range(0, 15)), draw_q(32'h4_0000),
                     draw_q(32'h1_8000), 1'b0, '0);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
